@@ rtl/tsq_pkg.sv @@
// Shared types and codes for the timestamp-ordered request queue.
`timescale 1ns / 1ps
package tsq_pkg;

  localparam int IdW     = 8;
  localparam int TimeW   = 32;
  localparam int WeightW = 16;
  localparam int StatusW = 2;
  localparam int OccW    = 5;

  localparam logic KIND_ENQ = 1'b0;
  localparam logic KIND_DEQ = 1'b1;

  localparam logic [StatusW-1:0] ST_OK    = 2'd0;
  localparam logic [StatusW-1:0] ST_EMPTY = 2'd1;
  localparam logic [StatusW-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic               kind;
    logic [IdW-1:0]     req_id;
    logic [TimeW-1:0]   req_time;
    logic [WeightW-1:0] req_weight;
  } tsq_req_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [IdW-1:0]     head_id;
    logic [TimeW-1:0]   head_time;
    logic [WeightW-1:0] head_weight;
    logic [OccW-1:0]    occupancy;
  } tsq_rsp_t;

  typedef struct packed {
    logic [IdW-1:0]     id;
    logic [TimeW-1:0]   ts;
    logic [WeightW-1:0] weight;
  } tsq_entry_t;

  typedef struct packed {
    logic enq;
    logic deq;
  } tsq_slot_ctl_t;

endpackage

@@ rtl/timestamp_ordered_request_queue_top.sv @@
// Top level of the timestamp-ordered request queue.
`timescale 1ns / 1ps
// Sorted queue of up to DEPTH requests, ordered by timestamp, then lower id,
// then arrival. One operation (enqueue or dequeue) is taken every clock cycle;
// busy stays low, so start may be held high continuously. Each operation
// yields exactly one result on rsp_o with done_o high for one cycle: the
// operation is first captured in the input register (in_q, in_vld_q), and
// done_o and rsp_o are registered from that stage. The receiver cannot stall.
// The cycle budget is set by one parallel compare of the new key against all
// DEPTH slots followed by a one-position shift of the slot array.
module timestamp_ordered_request_queue_top
  import tsq_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  input  tsq_req_t req_i,
  output logic     busy,
  output logic     done_o,
  output tsq_rsp_t rsp_o
);

  localparam int CntW = $clog2(DEPTH + 1);

  tsq_req_t       in_q;
  logic           in_vld_q;
  logic [CntW-1:0] count_q, count_d;
  tsq_rsp_t       rsp_q, rsp_d;
  logic           done_q;

  tsq_slot_ctl_t  ctl;
  tsq_entry_t     new_entry;
  tsq_entry_t     slot [DEPTH];
  logic           ahead [DEPTH];
  logic           full, empty;

  assign busy = 1'b0;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= start & ~busy;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      in_q <= req_i;
    end
  end

  assign full  = (count_q == CntW'(DEPTH));
  assign empty = (count_q == '0);

  assign new_entry.id     = in_q.req_id;
  assign new_entry.ts     = in_q.req_time;
  assign new_entry.weight = in_q.req_weight;

  assign ctl.enq = in_vld_q && (in_q.kind == KIND_ENQ) && !full;
  assign ctl.deq = in_vld_q && (in_q.kind == KIND_DEQ) && !empty;

  for (genvar k = 0; k < DEPTH; k++) begin : g_slot
    tsq_entry_t prev_e, next_e;
    logic       prev_ahead;

    if (k == 0) begin : g_first
      assign prev_e     = new_entry;
      assign prev_ahead = 1'b1;
    end else begin : g_mid
      assign prev_e     = slot[k-1];
      assign prev_ahead = ahead[k-1];
    end

    if (k == DEPTH - 1) begin : g_last
      assign next_e = slot[k];
    end else begin : g_inner
      assign next_e = slot[k+1];
    end

    tsq_slot u_slot (
      .clk_i        (clk_i),
      .ctl_i        (ctl),
      .valid_i      (count_q > CntW'(k)),
      .new_i        (new_entry),
      .prev_i       (prev_e),
      .prev_ahead_i (prev_ahead),
      .next_i       (next_e),
      .ahead_o      (ahead[k]),
      .entry_o      (slot[k])
    );
  end

  always_comb begin
    count_d = count_q;
    rsp_d   = '0;
    if (ctl.enq) begin
      count_d = count_q + CntW'(1);
    end else if (ctl.deq) begin
      count_d           = count_q - CntW'(1);
      rsp_d.head_id     = slot[0].id;
      rsp_d.head_time   = slot[0].ts;
      rsp_d.head_weight = slot[0].weight;
    end
    unique case (in_q.kind)
      KIND_ENQ: rsp_d.status = full  ? ST_FULL  : ST_OK;
      KIND_DEQ: rsp_d.status = empty ? ST_EMPTY : ST_OK;
      default:  rsp_d.status = ST_OK;
    endcase
    rsp_d.occupancy = OccW'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      done_q  <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_vld_q) begin
      rsp_q <= rsp_d;
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

`ifndef SYNTHESIS
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(DEPTH))
    else $error("fill count above depth");

  a_one_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##2 done_o)
    else $error("accepted operation produced no result");

  a_full_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.status == ST_FULL) |-> (count_q == $past(count_q)))
    else $error("dropped request changed the fill count");

  a_err_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.status != ST_OK) |->
      (rsp_o.head_id == '0 && rsp_o.head_time == '0 && rsp_o.head_weight == '0))
    else $error("error result carries head data");

  a_empty_deq : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.status == ST_EMPTY) |-> (count_q == '0))
    else $error("empty status with stored requests");
`endif

endmodule

@@ rtl/tsq_slot.sv @@
// One queue slot: key compare against the incoming request and shift/insert mux.
`timescale 1ns / 1ps
module tsq_slot
  import tsq_pkg::*;
(
  input  logic          clk_i,
  input  tsq_slot_ctl_t ctl_i,
  input  logic          valid_i,
  input  tsq_entry_t    new_i,
  input  tsq_entry_t    prev_i,
  input  logic          prev_ahead_i,
  input  tsq_entry_t    next_i,
  output logic          ahead_o,
  output tsq_entry_t    entry_o
);

  tsq_entry_t entry_q, entry_d;
  logic       stays;

  always_comb begin
    stays = (entry_q.ts < new_i.ts) ||
            ((entry_q.ts == new_i.ts) && (entry_q.id <= new_i.id));
    ahead_o = valid_i & stays;

    entry_d = entry_q;
    if (ctl_i.enq) begin
      // keep if ahead, else take the new beat at the boundary or shift down
      if (!ahead_o) begin
        entry_d = prev_ahead_i ? new_i : prev_i;
      end
    end else if (ctl_i.deq) begin
      entry_d = next_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

@@ bench/timestamp_ordered_request_queue_top_tb.sv @@
// Self-checking bench for the timestamp-ordered request queue top level.
`timescale 1ns / 1ps
module timestamp_ordered_request_queue_top_tb;
  import tsq_pkg::*;

  localparam int DEPTH = 16;

  logic     clk_i;
  logic     rst_ni;
  logic     start;
  tsq_req_t req_i;
  logic     busy;
  logic     done_o;
  tsq_rsp_t rsp_o;

  // Shadow copy of the sorted slots, head in entry 0.
  tsq_entry_t  queue_slot[DEPTH];
  int          queue_fill;
  tsq_rsp_t    pending_rsp_q[$];
  int unsigned mismatch_cnt;
  bit          idle_on;

  timestamp_ordered_request_queue_top #(
    .DEPTH(DEPTH)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .req_i (req_i),
    .busy  (busy),
    .done_o(done_o),
    .rsp_o (rsp_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("timestamp_ordered_request_queue_top_tb: errors");
    $finish;
  end

  // Insert or pop on the shadow queue and return the response it implies.
  function automatic tsq_rsp_t queue_apply(tsq_req_t op);
    tsq_rsp_t rsp;
    int       pos;
    rsp = '0;
    if (op.kind == KIND_ENQ) begin
      if (queue_fill >= DEPTH) begin
        rsp.status = ST_FULL;
      end else begin
        pos = 0;
        // Equal keys stay ahead, so ties leave in arrival order.
        while (pos < queue_fill &&
               (queue_slot[pos].ts < op.req_time ||
                (queue_slot[pos].ts == op.req_time && queue_slot[pos].id <= op.req_id)))
          pos++;
        for (int k = queue_fill; k > pos; k--) queue_slot[k] = queue_slot[k-1];
        queue_slot[pos] = '{id: op.req_id, ts: op.req_time, weight: op.req_weight};
        queue_fill++;
      end
    end else if (queue_fill == 0) begin
      rsp.status = ST_EMPTY;
    end else begin
      rsp.head_id     = queue_slot[0].id;
      rsp.head_time   = queue_slot[0].ts;
      rsp.head_weight = queue_slot[0].weight;
      for (int k = 1; k < queue_fill; k++) queue_slot[k-1] = queue_slot[k];
      queue_fill--;
    end
    rsp.occupancy = OccW'(queue_fill);
    return rsp;
  endfunction

  function automatic tsq_req_t make_op(logic kind, int unsigned id, logic [31:0] ts,
                                       int unsigned weight);
    tsq_req_t op;
    op.kind       = kind;
    op.req_id     = IdW'(id);
    op.req_time   = ts;
    op.req_weight = WeightW'(weight);
    return op;
  endfunction

  // Tight keys crowd both ends of the key space to force ties.
  function automatic tsq_req_t random_op(int unsigned enq_pct, bit tight_keys);
    tsq_req_t op;
    op.kind       = ($urandom_range(99) < enq_pct) ? KIND_ENQ : KIND_DEQ;
    op.req_weight = WeightW'($urandom);
    if (tight_keys) begin
      op.req_id   = $urandom_range(1) ? IdW'($urandom_range(2)) : IdW'(255 - $urandom_range(2));
      op.req_time = $urandom_range(1) ? 32'($urandom_range(3))
                                      : 32'hFFFF_FFFC + 32'($urandom_range(3));
    end else begin
      op.req_id   = IdW'($urandom);
      op.req_time = $urandom;
    end
    return op;
  endfunction

  // Present one beat; start stays high until an idle cycle (idle_on), the next beat or drop_start.
  task automatic send_op(tsq_req_t op);
    while (idle_on && $urandom_range(99) < 37) begin
      @(negedge clk_i);
      start <= 1'b0;
      req_i <= tsq_req_t'({$urandom, 25'($urandom)});
    end
    @(negedge clk_i);
    start <= 1'b1;
    req_i <= op;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    pending_rsp_q.push_back(queue_apply(op));
  endtask

  task automatic drop_start();
    @(negedge clk_i);
    start <= 1'b0;
    req_i <= '0;
  endtask

  task automatic note_mismatch(string field, logic [31:0] want, logic [31:0] got);
    if (mismatch_cnt < 10)
      $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $realtime, field, want, got);
    mismatch_cnt++;
  endtask

  always @(posedge clk_i) begin
    tsq_rsp_t want;
    if (rst_ni && done_o) begin
      if (pending_rsp_q.size() == 0) begin
        if (mismatch_cnt < 10) $display("%0t: result beat with nothing pending", $realtime);
        mismatch_cnt++;
      end else begin
        want = pending_rsp_q.pop_front();
        if (rsp_o.status != want.status)
          note_mismatch("status", 32'(want.status), 32'(rsp_o.status));
        if (rsp_o.head_id != want.head_id)
          note_mismatch("head_id", 32'(want.head_id), 32'(rsp_o.head_id));
        if (rsp_o.head_time != want.head_time)
          note_mismatch("head_time", want.head_time, rsp_o.head_time);
        if (rsp_o.head_weight != want.head_weight)
          note_mismatch("head_weight", 32'(want.head_weight), 32'(rsp_o.head_weight));
        if (rsp_o.occupancy != want.occupancy)
          note_mismatch("occupancy", 32'(want.occupancy), 32'(rsp_o.occupancy));
      end
    end
  end

  // Empty dequeue, key extremes, lower id first on equal time, exact tie.
  task automatic test_order_and_ties();
    send_op(make_op(KIND_DEQ, 255, 32'hFFFF_FFFF, 16'hFFFF));
    send_op(make_op(KIND_ENQ, 8, 32'd100, 1));
    send_op(make_op(KIND_ENQ, 3, 32'd100, 2));
    send_op(make_op(KIND_ENQ, 3, 32'd100, 3));
    send_op(make_op(KIND_ENQ, 255, 32'hFFFF_FFFF, 16'hFFFF));
    send_op(make_op(KIND_ENQ, 0, 32'd0, 0));
    send_op(make_op(KIND_DEQ, 0, 32'd0, 0));
    send_op(make_op(KIND_DEQ, 0, 32'd0, 16'h5A5A));
  endtask

  // Fill to the brim, then push one more that must be dropped.
  task automatic test_full_drop();
    for (int n = 0; n < DEPTH - 3; n++) send_op(random_op(100, n[0]));
    send_op(make_op(KIND_ENQ, 0, 32'd0, 16'hFFFF));
  endtask

  // Phases with varying enqueue bias sweep the queue between empty and full.
  task automatic test_random_mix();
    int unsigned enq_pct;
    bit          tight;
    for (int phase = 0; phase < 20; phase++) begin
      case ($urandom_range(4))
        0:       enq_pct = 10;
        1:       enq_pct = 30;
        2:       enq_pct = 50;
        3:       enq_pct = 70;
        default: enq_pct = 90;
      endcase
      tight = 1'($urandom_range(1));
      for (int n = 0; n < 80; n++) send_op(random_op(enq_pct, tight));
    end
  endtask

  task automatic test_back_to_back();
    idle_on = 1'b0;
    for (int n = 0; n < 300; n++) send_op(random_op(n < 150 ? 65 : 40, 1'($urandom_range(1))));
    idle_on = 1'b1;
  endtask

  initial begin
    rst_ni       = 1'b0;
    start        = 1'b0;
    req_i        = '0;
    queue_fill   = 0;
    mismatch_cnt = 0;
    idle_on      = 1'b1;
    for (int k = 0; k < DEPTH; k++) queue_slot[k] = '0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    test_order_and_ties();
    test_full_drop();
    test_random_mix();
    test_back_to_back();
    drop_start();

    while (pending_rsp_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatch_cnt == 0 && pending_rsp_q.size() == 0) begin
      $display("timestamp_ordered_request_queue_top_tb: clean");
    end else begin
      $display("timestamp_ordered_request_queue_top_tb: errors");
    end
    $finish;
  end

endmodule
